@@ src/flowshop_node_bound_evaluator_top_defines.svh @@
// Assertion macros shared by the flow shop bound evaluator checker.
// Depends on nothing; included by the checker file only.
`ifndef FLOWSHOP_NODE_BOUND_EVALUATOR_TOP_DEFINES_SVH
`define FLOWSHOP_NODE_BOUND_EVALUATOR_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define FNB_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define FNB_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ src/fnbe_pkg.sv @@
// Package for the flow shop bound evaluator: field widths, codes and FSM states.
// No dependencies.
`timescale 1ns / 1ps
package fnbe_pkg;
  localparam int unsigned MaxJobs  = 64;
  localparam int unsigned TimeBits = 16;
  localparam int unsigned DoneBits = 24;
  localparam int unsigned SumBits  = 22;
  localparam int unsigned PrioBits = 41;
  localparam int unsigned DivBits  = 64;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ROOT   = 2'd1,
    ACT_APPEND = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_JOB = 2'd1,
    ST_NO_FREE = 2'd2
  } status_t;

  localparam logic [0:0] CFG_JOB_COUNT = 1'b0;
  localparam logic [0:0] CFG_PRIO      = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT, S_CHECK, S_APPEND, S_SCAN, S_BOUND,
    S_MUL1, S_MUL2, S_DIV, S_PRIO, S_LAST, S_OUT
  } state_t;
endpackage

@@ src/fnbe_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the weighted priority.
// Depends on fnbe_pkg.
`timescale 1ns / 1ps
module fnbe_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fnbe_pkg::DivBits-1:0]  dividend,
  input  logic [7:0]                    divisor,
  output logic                          busy,
  output logic [fnbe_pkg::DivBits-1:0]  quotient
);
  logic [fnbe_pkg::DivBits-1:0] q_r, q_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [8:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {rem_r[7:0], q_r[fnbe_pkg::DivBits-1]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'(fnbe_pkg::DivBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        q_nxt = {q_r[fnbe_pkg::DivBits-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[fnbe_pkg::DivBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign quotient = q_r;
endmodule

@@ src/flowshop_node_bound_evaluator_top.sv @@
// Top level of the three-machine flow shop bound evaluator.
// Depends on fnbe_pkg and fnbe_divider.
//
// Usage: each beat on the in_ channel carries one action (load, root, append
// or none). The block answers every accepted beat with exactly one result beat
// on the out_ channel: status, machine completion times, lower bound,
// priority, depth, feasibility and, when at most one job is free, the makespan.
// Registers are written on the cfg_ channel (index 0 job count, index 1
// priority weight) while the block is idle.
// Sequencing: one item is handled by a sequencer over the time table memory,
// which has one read port and one write port. Every item ends with a scan of
// all MAX_JOBS entries, one per cycle, and the states S_BOUND, S_MUL1, S_MUL2,
// S_PRIO, S_LAST and S_OUT then form the bound, priority and result. With a
// positive weight a bit-serial division of the 64-bit product (S_DIV) is
// added. Before the scan a load adds a write, an append a check and a read,
// and a root a sweep over its n entries.
// in_tready is high only when the sequencer is idle; the next item is taken
// as soon as the result moves into the output register.
// Reset clears the schedule, the free set and the priority weight, and sets the
// job count to 2; the time table holds no values until loaded. A low out_tready
// keeps the result in the output register, and the next item waits in S_OUT.
`timescale 1ns / 1ps
module flowshop_node_bound_evaluator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // job[5:0], time_m1[21:6], time_m2[37:22], time_m3[53:38], zero [55:54]
  input  logic [55:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], finish_m1[25:2], finish_m2[49:26], finish_m3[73:50],
  // lower_bound[97:74], priority_res[138:98], makespan[162:139],
  // depth[169:163], zero [175:170]
  output logic [175:0] out_tdata,
  // feasible[0], solution_valid[1]
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [10:0]  cfg_data
);
  localparam int unsigned MAX_JOBS  = fnbe_pkg::MaxJobs;
  localparam int unsigned TIME_BITS = fnbe_pkg::TimeBits;
  localparam int unsigned JB = $clog2(MAX_JOBS);
  localparam int unsigned CB = $clog2(MAX_JOBS + 1);
  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned EB = 3 * TB;

  // ---------------- registers ----------------
  fnbe_pkg::state_t state_r, state_nxt;
  logic [6:0]  job_count_r;
  logic signed [10:0] prio_w_r;
  logic [MAX_JOBS-1:0] free_r, free_nxt;
  logic [23:0] d1_r, d1_nxt, d2_r, d2_nxt, d3_r, d3_nxt;
  logic [6:0]  sc_r, sc_nxt;
  logic [21:0] rs2_r, rs2_nxt, rs3_r, rs3_nxt, ts1_r, ts1_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [5:0]  job_r, job_nxt;
  logic [47:0] tin_r, tin_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [CB-1:0] idx_r, idx_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [JB-1:0] rd_idx_r;
  logic [TB:0] min3_r, min3_nxt;
  logic [TB+1:0] min23_r, min23_nxt;
  logic        any_r, any_nxt;
  logic [1:0]  nfree_r, nfree_nxt;
  logic [JB-1:0] last_r, last_nxt;
  logic [23:0] lb_r, lb_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt;
  logic signed [63:0] pr_r, pr_nxt;
  logic [23:0] mk_r, mk_nxt;
  logic        sv_r, sv_nxt;
  logic        ov_r, ov_nxt;
  logic [175:0] od_r;
  logic [1:0]  ou_r;

  // ---------------- time table memory ----------------
  logic [EB-1:0] mem [MAX_JOBS];
  logic          mem_we;
  logic [JB-1:0] mem_wa, mem_ra;
  logic [EB-1:0] mem_q;

  function automatic logic [EB-1:0] mem_wdata();
    mem_wdata = {tin_r[32+TB-1:32], tin_r[16+TB-1:16], tin_r[TB-1:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wdata();
    mem_q <= mem[mem_ra];
  end

  logic [TB-1:0] q1, q2, q3;
  assign q1 = mem_q[TB-1:0];
  assign q2 = mem_q[2*TB-1:TB];
  assign q3 = mem_q[3*TB-1:2*TB];

  // clamped job count
  logic [CB:0] n_c;
  always_comb begin
    if (job_count_r < 7'd2) n_c = (CB+1)'(2);
    else if (32'(job_count_r) > MAX_JOBS) n_c = (CB+1)'(MAX_JOBS);
    else n_c = (CB+1)'(job_count_r);
  end

  // divider
  logic div_start, div_busy;
  logic [63:0] div_q;
  logic [7:0] div_den;
  assign div_den = 8'(n_c - 1'b1);
  fnbe_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_r),
    .divisor(div_den), .busy(div_busy), .quotient(div_q)
  );

  function automatic logic [23:0] sat24(input logic [25:0] v);
    sat24 = (v[25:24] != 2'b00) ? 24'hFFFFFF : v[23:0];
  endfunction
  function automatic logic [21:0] sat22(input logic [22:0] v);
    sat22 = v[22] ? 22'h3FFFFF : v[21:0];
  endfunction

  logic in_fire, out_fire;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready = (state_r == fnbe_pkg::S_IDLE);
  assign cfg_ready = (state_r == fnbe_pkg::S_IDLE);

  logic [25:0] t_a, t_b, t_c;
  logic [25:0] b1, b2, b3, bm;
  logic [24:0] f1, f2, f3;
  logic [JB-1:0] jidx;
  assign jidx = job_r[JB-1:0];

  always_comb begin
    state_nxt = state_r;
    free_nxt = free_r;
    d1_nxt = d1_r; d2_nxt = d2_r; d3_nxt = d3_r;
    sc_nxt = sc_r;
    rs2_nxt = rs2_r; rs3_nxt = rs3_r; ts1_nxt = ts1_r;
    act_nxt = act_r; job_nxt = job_r; tin_nxt = tin_r;
    status_nxt = status_r;
    idx_nxt = idx_r;
    rd_pend_nxt = 1'b0;
    min3_nxt = min3_r; min23_nxt = min23_r; any_nxt = any_r;
    nfree_nxt = nfree_r; last_nxt = last_r;
    lb_nxt = lb_r; acc_nxt = acc_r; neg_nxt = neg_r; pr_nxt = pr_r;
    mk_nxt = mk_r; sv_nxt = sv_r;
    mem_we = 1'b0; mem_wa = jidx; mem_ra = idx_r[JB-1:0];
    div_start = 1'b0;
    t_a = '0; t_b = '0; t_c = '0; b1 = '0; b2 = '0; b3 = '0; bm = '0;
    f1 = '0; f2 = '0; f3 = '0;
    ov_nxt = ov_r;
    if (out_fire) ov_nxt = 1'b0;

    case (state_r)
      fnbe_pkg::S_IDLE: begin
        if (in_fire) begin
          act_nxt = in_tuser;
          job_nxt = in_tdata[5:0];
          tin_nxt = in_tdata[53:6];
          status_nxt = fnbe_pkg::ST_OK;
          idx_nxt = '0;
          case (fnbe_pkg::action_t'(in_tuser))
            fnbe_pkg::ACT_LOAD: begin
              if (32'(in_tdata[5:0]) >= MAX_JOBS) status_nxt = fnbe_pkg::ST_BAD_JOB;
              state_nxt = fnbe_pkg::S_SCAN;
              if (32'(in_tdata[5:0]) < MAX_JOBS) state_nxt = fnbe_pkg::S_APPEND;
            end
            fnbe_pkg::ACT_ROOT: begin
              d1_nxt = '0; d2_nxt = '0; d3_nxt = '0; sc_nxt = '0;
              rs2_nxt = '0; rs3_nxt = '0; ts1_nxt = '0;
              free_nxt = '0;
              state_nxt = fnbe_pkg::S_ROOT;
            end
            fnbe_pkg::ACT_APPEND: state_nxt = fnbe_pkg::S_CHECK;
            default: state_nxt = fnbe_pkg::S_SCAN;
          endcase
          min3_nxt = '0; min23_nxt = '0; any_nxt = 1'b0; nfree_nxt = '0;
          last_nxt = '0;
        end
      end
      // Root sweep: read entries 0..n-1 and fold them into the sums.
      fnbe_pkg::S_ROOT: begin
        if ({1'b0, idx_r} < n_c) begin
          rd_pend_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_pend_r) begin
          free_nxt[rd_idx_r] = 1'b1;
          ts1_nxt = sat22({1'b0, ts1_r} + 23'(q1));
          rs2_nxt = sat22({1'b0, rs2_r} + 23'(q2));
          rs3_nxt = sat22({1'b0, rs3_r} + 23'(q3));
        end
        if (!rd_pend_r && {1'b0, idx_r} >= n_c) begin
          idx_nxt = '0;
          state_nxt = fnbe_pkg::S_SCAN;
        end
      end
      fnbe_pkg::S_CHECK: begin
        mem_ra = jidx;
        if (free_r == '0) begin
          status_nxt = fnbe_pkg::ST_NO_FREE;
          state_nxt = fnbe_pkg::S_SCAN;
        end else if ({1'b0, job_r} >= 7'(n_c) || !free_r[jidx]) begin
          status_nxt = fnbe_pkg::ST_BAD_JOB;
          state_nxt = fnbe_pkg::S_SCAN;
        end else begin
          rd_pend_nxt = 1'b1;
          state_nxt = fnbe_pkg::S_APPEND;
        end
      end
      // Load write, or append update once the job's times are read.
      fnbe_pkg::S_APPEND: begin
        if (act_r == fnbe_pkg::ACT_LOAD) begin
          mem_we = 1'b1;
          state_nxt = fnbe_pkg::S_SCAN;
        end else if (rd_pend_r) begin
          t_a = 26'(sat24(26'(d1_r) + 26'(q1)));
          t_b = 26'(sat24(26'((d2_r > t_a[23:0]) ? d2_r : t_a[23:0]) + 26'(q2)));
          t_c = 26'(sat24(26'((d3_r > t_b[23:0]) ? d3_r : t_b[23:0]) + 26'(q3)));
          d1_nxt = t_a[23:0]; d2_nxt = t_b[23:0]; d3_nxt = t_c[23:0];
          rs2_nxt = (rs2_r > 22'(q2)) ? rs2_r - 22'(q2) : '0;
          rs3_nxt = (rs3_r > 22'(q3)) ? rs3_r - 22'(q3) : '0;
          free_nxt[jidx] = 1'b0;
          sc_nxt = (sc_r == 7'h7F) ? sc_r : sc_r + 7'd1;
          state_nxt = fnbe_pkg::S_SCAN;
        end else begin
          rd_pend_nxt = 1'b1;
          mem_ra = jidx;
        end
      end
      // Scan over all entries for the least free times.
      fnbe_pkg::S_SCAN: begin
        if (32'(idx_r) < MAX_JOBS) begin
          rd_pend_nxt = free_r[idx_r[JB-1:0]];
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_pend_r) begin
          if (!any_r || (TB+1)'(q3) < min3_r) min3_nxt = (TB+1)'(q3);
          if (!any_r || (TB+2)'(q2) + (TB+2)'(q3) < min23_r)
            min23_nxt = (TB+2)'(q2) + (TB+2)'(q3);
          any_nxt = 1'b1;
          if (nfree_r != 2'd2) nfree_nxt = nfree_r + 2'd1;
          last_nxt = rd_idx_r;
        end
        if (!rd_pend_r && 32'(idx_r) >= MAX_JOBS) state_nxt = fnbe_pkg::S_BOUND;
      end
      fnbe_pkg::S_BOUND: begin
        b1 = 26'(d3_r) + 26'(rs3_r);
        b2 = 26'(d2_r) + 26'(rs2_r) + 26'(min3_r);
        b3 = 26'(ts1_r) + 26'(min23_r);
        bm = (b1 > b2) ? b1 : b2;
        bm = (bm > b3) ? bm : b3;
        lb_nxt = sat24(bm);
        mem_ra = last_r;
        state_nxt = fnbe_pkg::S_MUL1;
      end
      fnbe_pkg::S_MUL1: begin
        // |(d-1)*p| and its sign; d <= 127, p <= 1023.
        if (sc_r == 7'd0) begin
          acc_nxt = 64'(prio_w_r);
          neg_nxt = 1'b1;
        end else begin
          acc_nxt = 64'(sc_r - 7'd1) * 64'(prio_w_r);
          neg_nxt = 1'b0;
        end
        state_nxt = fnbe_pkg::S_MUL2;
      end
      fnbe_pkg::S_MUL2: begin
        acc_nxt = 64'({24'd0, acc_r[17:0]} * {18'd0, lb_r});
        if (prio_w_r > 0) begin
          div_start = 1'b0;
          state_nxt = fnbe_pkg::S_DIV;
        end else state_nxt = fnbe_pkg::S_PRIO;
      end
      fnbe_pkg::S_DIV: begin
        if (!div_busy && idx_r != '0) state_nxt = fnbe_pkg::S_PRIO;
        if (idx_r == '0) begin
          div_start = 1'b1;
          idx_nxt = (CB)'(1);
        end
      end
      fnbe_pkg::S_PRIO: begin
        // The last free job's times arrive in time for the makespan step.
        mem_ra = last_r;
        if (prio_w_r < 0)
          pr_nxt = 64'(sc_r) * 64'sd1000 - 64'(lb_r);
        else if (prio_w_r == 0)
          pr_nxt = -(64'(lb_r) * 64'sd1000) + 64'(sc_r);
        else
          pr_nxt = (neg_r ? -$signed(div_q) : $signed(div_q)) - 64'(lb_r) * 64'sd100;
        state_nxt = fnbe_pkg::S_LAST;
      end
      fnbe_pkg::S_LAST: begin
        f1 = 25'(d1_r) + 25'(q1);
        f2 = ((25'(d2_r) > f1) ? 25'(d2_r) : f1) + 25'(q2);
        f3 = ((25'(d3_r) > f2) ? 25'(d3_r) : f2) + 25'(q3);
        sv_nxt = (nfree_r != 2'd2);
        if (nfree_r == 2'd0) mk_nxt = d3_r;
        else if (nfree_r == 2'd1) mk_nxt = sat24(26'(f3));
        else mk_nxt = '0;
        state_nxt = fnbe_pkg::S_OUT;
      end
      fnbe_pkg::S_OUT: begin
        if (!ov_r || out_fire) begin
          ov_nxt = 1'b1;
          state_nxt = fnbe_pkg::S_IDLE;
        end
      end
      default: state_nxt = fnbe_pkg::S_IDLE;
    endcase
  end

  logic signed [40:0] pr_sat;
  localparam logic signed [63:0] PHi = 64'sd1099511627775;
  always_comb begin
    if (pr_r > PHi) pr_sat = 41'(PHi);
    else if (pr_r < -PHi - 64'sd1) pr_sat = 41'(-PHi - 64'sd1);
    else pr_sat = pr_r[40:0];
  end

  logic feas;
  assign feas = (8'(sc_r) + 8'd1) >= 8'(n_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fnbe_pkg::S_IDLE;
      job_count_r <= 7'd2;
      prio_w_r <= '0;
      free_r <= '0;
      d1_r <= '0; d2_r <= '0; d3_r <= '0; sc_r <= '0;
      rs2_r <= '0; rs3_r <= '0; ts1_r <= '0;
      rd_pend_r <= 1'b0;
      idx_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fnbe_pkg::CFG_JOB_COUNT) job_count_r <= cfg_data[6:0];
        else prio_w_r <= $signed(cfg_data);
      end
      free_r <= free_nxt;
      d1_r <= d1_nxt; d2_r <= d2_nxt; d3_r <= d3_nxt; sc_r <= sc_nxt;
      rs2_r <= rs2_nxt; rs3_r <= rs3_nxt; ts1_r <= ts1_nxt;
      rd_pend_r <= rd_pend_nxt;
      idx_r <= (state_r == fnbe_pkg::S_BOUND) ? '0 : idx_nxt;
      ov_r <= ov_nxt;
    end
    rd_idx_r <= idx_r[JB-1:0];
    act_r <= act_nxt; job_r <= job_nxt; tin_r <= tin_nxt; status_r <= status_nxt;
    min3_r <= min3_nxt; min23_r <= min23_nxt; any_r <= any_nxt;
    nfree_r <= nfree_nxt; last_r <= last_nxt;
    lb_r <= lb_nxt; acc_r <= acc_nxt; neg_r <= neg_nxt; pr_r <= pr_nxt;
    mk_r <= mk_nxt; sv_r <= sv_nxt;
    if (state_r == fnbe_pkg::S_OUT && (!ov_r || out_fire)) begin
      od_r <= {6'd0, sc_r, mk_r, pr_sat, lb_r, d3_r, d2_r, d1_r, status_r};
      ou_r <= {sv_r, feas};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
endmodule

@@ src/fnbe_checker.sv @@
// Port-level checker for the flow shop bound evaluator, bound to the top.
// Depends on flowshop_node_bound_evaluator_top_defines.svh.
`timescale 1ns / 1ps
`include "flowshop_node_bound_evaluator_top_defines.svh"
module fnbe_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [175:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         cfg_ready
);
  // The block works on one item at a time and closes input right after a beat.
  `FNB_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // A stalled result keeps its payload.
  `FNB_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  // The configuration port opens together with the input channel.
  `FNB_ASSERT_IMP(a_cfg_idle, clk, rst_n, 1'b1, cfg_ready == in_tready)
  // Makespan reads zero whenever no completed schedule is reported.
  `FNB_ASSERT_IMP(a_mk_zero, clk, rst_n, out_tvalid && !out_tuser[1],
                  out_tdata[162:139] == 24'd0)
endmodule

bind flowshop_node_bound_evaluator_top fnbe_checker u_fnbe_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .cfg_ready(cfg_ready)
);
